// ===== sv/qwt_pkg.sv =====
package qwt_pkg;

  localparam int LINE_BUFFER_BYTES = 1024;
  localparam int LBB_BITS = $clog2(LINE_BUFFER_BYTES);
  // column counter keeps at least the 10 reported bits
  localparam int COL_W = (LBB_BITS > 10) ? LBB_BITS : 10;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [2:0] KIND_NL    = 3'd0;
  localparam logic [2:0] KIND_STR   = 3'd1;
  localparam logic [2:0] KIND_EQ    = 3'd2;
  localparam logic [2:0] KIND_COMMA = 3'd3;
  localparam logic [2:0] KIND_OPEN  = 3'd4;
  localparam logic [2:0] KIND_CLOSE = 3'd5;
  localparam logic [2:0] KIND_EOF   = 3'd6;
  localparam logic [2:0] KIND_PANIC = 3'd7;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0a;
  localparam logic [7:0] CH_VT      = 8'h0b;
  localparam logic [7:0] CH_FF      = 8'h0c;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_EQ      = 8'h3d;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_OPEN    = 8'h7b;
  localparam logic [7:0] CH_CLOSE   = 8'h7d;
  localparam logic [7:0] CH_QUOTE   = 8'h27;

  typedef logic [COL_W-1:0] col_t;

  typedef struct packed {
    logic [2:0] kind;
    col_t       s;
    col_t       e;
  } tok_t;

  typedef struct packed {
    logic two;
    tok_t t0;
    tok_t t1;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  function automatic logic is_white(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) || (c == CH_NL);
  endfunction

  function automatic logic is_special(logic [7:0] c);
    return (c == CH_PERCENT) || (c == CH_EQ) || (c == CH_COMMA) || (c == CH_OPEN) ||
           (c == CH_CLOSE) || (c == CH_QUOTE);
  endfunction

  function automatic tok_t mk_tok(logic [2:0] kind, col_t s, col_t e);
    tok_t t;
    t.kind = kind;
    t.s = s;
    t.e = e;
    return t;
  endfunction

endpackage

// ===== sv/qwt_front.sv =====
module qwt_front import qwt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  input  logic       end_of_input_i,
  input  logic       q_full_i,
  output push_t      push_o
);

  localparam logic [2:0] M_BETWEEN = 3'd0;
  localparam logic [2:0] M_WORD    = 3'd1;
  localparam logic [2:0] M_QUOTE   = 3'd2;
  localparam logic [2:0] M_COMMENT = 3'd3;
  localparam logic [2:0] M_DISCARD = 3'd4;

  localparam col_t COL_LIMIT = COL_W'(LINE_BUFFER_BYTES - 2);
  localparam col_t COL_ONE   = COL_W'(1);
  localparam col_t COL_ZERO  = '0;

  logic [2:0] mode_q, mode_d;
  col_t       col_q, col_d;
  col_t       ts_q, ts_d;
  logic       lws_q, lws_d;

  tok_t       t0, t1;
  logic       n0, two;
  logic       nl, word_end;
  col_t       col_inc;
  tok_t       punct;
  logic       has_punct;

  assign in_ready_o = !q_full_i;
  assign nl = (ch_i == CH_NL);
  assign col_inc = col_q + COL_ONE;

  always_comb begin
    mode_d = mode_q;
    col_d = col_q;
    ts_d = ts_q;
    lws_d = lws_q;
    t0 = mk_tok(KIND_EOF, COL_ZERO, COL_ZERO);
    t1 = mk_tok(KIND_EOF, COL_ZERO, COL_ZERO);
    n0 = 1'b0;
    two = 1'b0;
    word_end = 1'b0;
    punct = mk_tok(KIND_EQ, col_q, col_inc);
    has_punct = 1'b0;
    priority if (end_of_input_i) begin
      n0 = 1'b1;
      if (mode_q == M_WORD || mode_q == M_QUOTE) begin
        t0 = mk_tok(KIND_STR, ts_q, col_q);
        two = 1'b1;
      end else if (mode_q == M_COMMENT || (mode_q == M_BETWEEN && lws_q)) begin
        t0 = mk_tok(KIND_NL, col_q, col_q);
        two = 1'b1;
      end
      mode_d = M_BETWEEN;
      col_d = '0;
      ts_d = '0;
      lws_d = 1'b0;
    end else if (mode_q == M_DISCARD) begin
      if (nl) begin
        mode_d = M_BETWEEN;
        col_d = '0;
        ts_d = '0;
        lws_d = 1'b0;
      end
    end else if (!nl && col_q >= COL_LIMIT) begin
      n0 = 1'b1;
      t0 = mk_tok(KIND_PANIC, COL_ZERO, COL_ZERO);
      mode_d = M_DISCARD;
    end else if (mode_q == M_QUOTE) begin
      if (ch_i == CH_QUOTE) begin
        n0 = 1'b1;
        t0 = mk_tok(KIND_STR, ts_q, col_q);
        mode_d = M_BETWEEN;
        lws_d = 1'b0;
        col_d = col_inc;
      end else if (nl) begin
        // unterminated quote swallows the newline
        n0 = 1'b1;
        t0 = mk_tok(KIND_STR, ts_q, col_inc);
        mode_d = M_BETWEEN;
        col_d = '0;
        ts_d = '0;
        lws_d = 1'b0;
      end else begin
        lws_d = 1'b0;
        col_d = col_inc;
      end
    end else if (mode_q == M_COMMENT) begin
      if (nl) begin
        n0 = 1'b1;
        two = 1'b1;
        t0 = mk_tok(KIND_NL, col_q, col_q);
        t1 = mk_tok(KIND_NL, col_inc, col_inc);
        mode_d = M_BETWEEN;
        col_d = '0;
        ts_d = '0;
        lws_d = 1'b0;
      end else begin
        col_d = col_inc;
      end
    end else if (mode_q == M_WORD && !is_white(ch_i) && !is_special(ch_i)) begin
      col_d = col_inc;
    end else begin
      // between tokens, or a word ended by this character
      word_end = (mode_q == M_WORD);
      if (word_end) begin
        mode_d = M_BETWEEN;
      end
      if (nl) begin
        has_punct = 1'b1;
        punct = mk_tok(KIND_NL, col_inc, col_inc);
        mode_d = M_BETWEEN;
        col_d = '0;
        ts_d = '0;
        lws_d = 1'b0;
      end else begin
        col_d = col_inc;
        if (is_white(ch_i)) begin
          lws_d = 1'b1;
        end else begin
          lws_d = 1'b0;
          priority case (ch_i)
            CH_PERCENT: mode_d = M_COMMENT;
            CH_EQ: begin
              has_punct = 1'b1;
              punct = mk_tok(KIND_EQ, col_q, col_inc);
            end
            CH_COMMA: begin
              has_punct = 1'b1;
              punct = mk_tok(KIND_COMMA, col_q, col_inc);
            end
            CH_OPEN: begin
              has_punct = 1'b1;
              punct = mk_tok(KIND_OPEN, col_q, col_inc);
            end
            CH_CLOSE: begin
              has_punct = 1'b1;
              punct = mk_tok(KIND_CLOSE, col_q, col_inc);
            end
            CH_QUOTE: begin
              mode_d = M_QUOTE;
              ts_d = col_inc;
            end
            default: begin
              mode_d = M_WORD;
              ts_d = col_q;
            end
          endcase
        end
      end
      if (word_end) begin
        n0 = 1'b1;
        t0 = mk_tok(KIND_STR, ts_q, col_q);
        two = has_punct;
        t1 = punct;
      end else begin
        n0 = has_punct;
        t0 = punct;
      end
    end
    // end of input always closes with eof
    if (end_of_input_i) begin
      if (two) begin
        t1 = mk_tok(KIND_EOF, COL_ZERO, COL_ZERO);
      end else begin
        t0 = mk_tok(KIND_EOF, COL_ZERO, COL_ZERO);
      end
    end
  end

  logic accept;
  assign accept = in_valid_i && in_ready_o;

  assign push_o.valid = accept && n0;
  assign push_o.entry.two = two;
  assign push_o.entry.t0 = t0;
  assign push_o.entry.t1 = t1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_BETWEEN;
      col_q <= '0;
      ts_q <= '0;
      lws_q <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      col_q <= col_d;
      ts_q <= ts_d;
      lws_q <= lws_d;
    end
  end

endmodule

// ===== sv/qwt_queue.sv =====
module qwt_queue import qwt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  push_i,
  output logic   full_o,
  output logic   head_valid_o,
  output entry_t head_o,
  input  logic   pop_i
);

  entry_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, rd_q;
  logic [QCNT_W-1:0]   cnt_q;

  assign full_o = (cnt_q == QCNT_W'(QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.valid) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      unique case ({push_i.valid, pop_i})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> !full_o)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ===== sv/qwt_back.sv =====
module qwt_back import qwt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  entry_t     head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] token_kind_o,
  output logic [9:0] start_col_o,
  output logic [9:0] end_col_o,
  output logic       last_o
);

  logic idx_q;
  logic valid_q;
  tok_t tok_q;
  logic last_q;
  logic load, final_tok;
  tok_t sel;

  assign load = head_valid_i && (!valid_q || out_ready_i);
  assign final_tok = !head_i.two || idx_q;
  assign sel = idx_q ? head_i.t1 : head_i.t0;
  assign pop_o = load && final_tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q <= !final_tok;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tok_q <= sel;
      last_q <= final_tok;
    end
  end

  assign out_valid_o = valid_q;
  assign token_kind_o = tok_q.kind;
  assign start_col_o = tok_q.s[9:0];
  assign end_col_o = tok_q.e[9:0];
  assign last_o = last_q;

`ifndef ASSERT_OFF
  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> out_valid_o)
    else $error("second token of an item missing");
  a_idx_has_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q |-> (head_valid_i && head_i.two))
    else $error("second slot selected without a pair");
  a_pop_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && head_i.two) |-> idx_q)
    else $error("pair popped before its second token");
`endif

endmodule

// ===== sv/quoted_word_tokenizer.sv =====
// channel  direction  handshake              payload
// in       input      in_valid_i/in_ready_o  ch_i, end_of_input_i
// out      output     out_valid_o/out_ready_i token_kind_o, start_col_o, end_col_o, last_o
//
// one character a cycle while the queue is not full; the scanner state updates in the same cycle it is taken
// an item giving two tokens is offered as two output transfers, absorbed by a four-entry queue
// first token of an item passes through the queue write, then the output register
// input stalls only when the queue is full; output stalls hold the token register
// asynchronous active-low reset returns to the start of a fresh line with the queue empty
module quoted_word_tokenizer import qwt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] token_kind_o,
  output logic [9:0] start_col_o,
  output logic [9:0] end_col_o,
  output logic       last_o
);

  push_t  push;
  logic   q_full;
  logic   head_valid;
  entry_t head;
  logic   pop;

  qwt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .ch_i          (ch_i),
    .end_of_input_i(end_of_input_i),
    .q_full_i      (q_full),
    .push_o        (push)
  );

  qwt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (q_full),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  qwt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .token_kind_o(token_kind_o),
    .start_col_o (start_col_o),
    .end_col_o   (end_col_o),
    .last_o      (last_o)
  );

endmodule
